// ----- rtl/pasm_pkg.sv -----
`default_nettype none
package pasm_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int COEF_W = 32;
    localparam int DEG_W = 4;
    localparam int ODEG_W = 5;
    localparam int REQ_W = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TERM_A = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TERM_B = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SUM = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIFF = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PROD = 3'd5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // tag that travels with each operand pair through the shared unit
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [1:0] op;
    } ctl_t;

endpackage
`default_nettype wire

// ----- rtl/pasm_store.sv -----
`default_nettype none
module pasm_store #(
    parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF,
    parameter int AW = $clog2(MAX_TERMS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          clear,
    input  wire logic                          wr_a,
    input  wire logic                          wr_b,
    input  wire logic [pasm_pkg::DEG_W-1:0]    wr_degree,
    input  wire logic [pasm_pkg::COEF_W-1:0]   wr_data,
    input  wire logic [AW-1:0]                 rd_a_idx,
    input  wire logic [AW-1:0]                 rd_b_idx,
    input  wire pasm_pkg::ctl_t                ctl_in,
    output logic [pasm_pkg::COEF_W-1:0]        a_q,
    output logic [pasm_pkg::COEF_W-1:0]        b_q,
    output pasm_pkg::ctl_t                     ctl_q
);

    logic [pasm_pkg::COEF_W-1:0] a_reg [MAX_TERMS];
    logic [pasm_pkg::COEF_W-1:0] b_reg [MAX_TERMS];
    logic [AW-1:0]               widx;
    logic                        in_range;

    assign widx = AW'(wr_degree);
    // degrees past the store are dropped
    assign in_range = (int'(wr_degree) < MAX_TERMS);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int n = 0; n < MAX_TERMS; n++) begin
                a_reg[n] <= '0;
                b_reg[n] <= '0;
            end
        end else begin
            if (wr_a && in_range) begin
                a_reg[widx] <= a_reg[widx] + wr_data;
            end
            if (wr_b && in_range) begin
                b_reg[widx] <= b_reg[widx] + wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_q <= a_reg[rd_a_idx];
        b_q <= b_reg[rd_b_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_q <= '0;
        end else begin
            ctl_q <= ctl_in;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pasm_mac.sv -----
`default_nettype none
module pasm_mac (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [pasm_pkg::COEF_W-1:0]   a_in,
    input  wire logic [pasm_pkg::COEF_W-1:0]   b_in,
    input  wire pasm_pkg::ctl_t                ctl_in,
    output logic                               res_valid,
    output logic [pasm_pkg::COEF_W-1:0]        res_value
);

    logic [pasm_pkg::COEF_W-1:0] p_reg;
    logic [pasm_pkg::COEF_W-1:0] p_next;
    logic [pasm_pkg::COEF_W-1:0] acc_reg;
    logic [pasm_pkg::COEF_W-1:0] acc_next;
    pasm_pkg::ctl_t              ctl1_reg;

    always_comb begin
        case (ctl_in.op)
            pasm_pkg::OP_ADD: p_next = a_in + b_in;
            pasm_pkg::OP_SUB: p_next = a_in - b_in;
            pasm_pkg::OP_MUL: p_next = a_in * b_in;
            default:          p_next = a_in + b_in;
        endcase
    end

    assign acc_next = ctl1_reg.first ? p_reg : acc_reg + p_reg;
    assign res_valid = ctl1_reg.valid && ctl1_reg.last;
    assign res_value = acc_next;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
        if (ctl1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else begin
            ctl1_reg <= ctl_in;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/polynomial_add_sub_multiply_core.sv -----
// clear and term beats leave the sequencer idle, so s_tready stays high
// sum or difference: MAX_TERMS results
// product: 2*MAX_TERMS-1 results, MAX_TERMS^2 multiply-accumulates
// on the one shared multiplier
// s_tready is low while a compute beat runs; results leave through one output register
// reset (aresetn low, synchronous) clears both coefficient stores and all control state
`default_nettype none
module polynomial_add_sub_multiply_core #(
    parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // degree[3:0], coefficient[35:4], zero pad
    input  wire logic [2:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_degree[4:0], out_coefficient[36:5], zero pad
    output logic             m_tlast
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int IW = $clog2(2 * MAX_TERMS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [IW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;

    logic [pasm_pkg::ODEG_W-1:0] odeg_reg;
    logic [pasm_pkg::COEF_W-1:0] ocoef_reg;
    logic                        olast_reg;
    logic                        ovalid_reg;

    logic          accept;
    logic [2:0]    kind;
    logic [IW-1:0] final_deg;
    logic [AW-1:0] j_lo, j_hi, k_idx;
    logic [AW-1:0] rd_a, rd_b;
    logic          is_mul, term_last, out_free;
    pasm_pkg::ctl_t ctl_issue, ctl_rd;

    logic [pasm_pkg::COEF_W-1:0] a_q, b_q, res_value;
    logic                        res_valid;

    function automatic logic [AW-1:0] lo_of(input logic [IW-1:0] x);
        if (int'(x) >= MAX_TERMS) begin
            return AW'(int'(x) - (MAX_TERMS - 1));
        end
        return '0;
    endfunction

    assign accept = s_tvalid && s_tready;
    assign kind = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);

    assign is_mul = (op_reg == pasm_pkg::OP_MUL);
    assign final_deg = is_mul ? IW'(2 * MAX_TERMS - 2) : IW'(MAX_TERMS - 1);
    assign j_lo = lo_of(i_reg);
    assign j_hi = (int'(i_reg) < MAX_TERMS) ? AW'(i_reg) : AW'(MAX_TERMS - 1);
    assign k_idx = AW'(int'(i_reg) - int'(j_reg));
    assign term_last = !is_mul || (j_reg == j_hi);
    assign rd_a = is_mul ? j_reg : AW'(i_reg);
    assign rd_b = is_mul ? k_idx : AW'(i_reg);
    assign out_free = !ovalid_reg || m_tready;

    always_comb begin
        ctl_issue.valid = (state_reg == ST_ISSUE);
        ctl_issue.first = !is_mul || (j_reg == j_lo);
        ctl_issue.last = term_last;
        ctl_issue.op = op_reg;
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        i_next = i_reg;
        j_next = j_reg;
        pend_next = pend_reg;
        if (res_valid) begin
            pend_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    i_next = '0;
                    j_next = '0;
                    if (kind == pasm_pkg::REQ_SUM) begin
                        op_next = pasm_pkg::OP_ADD;
                        state_next = ST_ISSUE;
                    end else if (kind == pasm_pkg::REQ_DIFF) begin
                        op_next = pasm_pkg::OP_SUB;
                        state_next = ST_ISSUE;
                    end else if (kind == pasm_pkg::REQ_PROD) begin
                        op_next = pasm_pkg::OP_MUL;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (term_last) begin
                    pend_next = 1'b1;
                    state_next = ST_WAIT;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                // next degree starts only once the output register is sure to be empty
                if (!pend_reg && out_free) begin
                    if (i_reg == final_deg) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                        j_next = lo_of(i_reg + 1'b1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= pasm_pkg::OP_ADD;
            i_reg <= '0;
            j_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            i_reg <= i_next;
            j_reg <= j_next;
            pend_reg <= pend_next;
        end
    end

    pasm_store #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (accept && (kind == pasm_pkg::REQ_CLEAR)),
        .wr_a      (accept && (kind == pasm_pkg::REQ_TERM_A)),
        .wr_b      (accept && (kind == pasm_pkg::REQ_TERM_B)),
        .wr_degree (s_tdata[3:0]),
        .wr_data   (s_tdata[35:4]),
        .rd_a_idx  (rd_a),
        .rd_b_idx  (rd_b),
        .ctl_in    (ctl_issue),
        .a_q       (a_q),
        .b_q       (b_q),
        .ctl_q     (ctl_rd)
    );

    pasm_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .a_in      (a_q),
        .b_in      (b_q),
        .ctl_in    (ctl_rd),
        .res_valid (res_valid),
        .res_value (res_value)
    );

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            odeg_reg <= pasm_pkg::ODEG_W'(i_reg);
            ocoef_reg <= res_value;
            olast_reg <= (i_reg == final_deg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (res_valid) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {3'b000, ocoef_reg, odeg_reg};
    assign m_tlast = olast_reg;

    // a finished coefficient never lands on a beat still waiting in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !ovalid_reg)
        else $error("result overwrote a pending output beat");

    // an outstanding result exists only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_WAIT))
        else $error("result pending outside wait state");

    // no new request is taken while results are still in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!pend_reg && !ctl_rd.valid))
        else $error("ready while the shared unit is busy");

    // the last flag of a run goes out only when the sequencer returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_IDLE))
        else $error("last beat left with the run unfinished");

endmodule
`default_nettype wire
